// File: rtl/sha256_message_hasher_defines.svh
// Assertion macros shared by the checker of the message hasher.
`ifndef SHA256_MESSAGE_HASHER_DEFINES_SVH
`define SHA256_MESSAGE_HASHER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SHAMH_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SHAMH_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/sha256mh_pkg.sv
package sha256mh_pkg;

   localparam int BLOCK_BYTES = 64;
   localparam int BLOCK_WORDS = BLOCK_BYTES / 4;
   localparam int ROUNDS = 64;

   typedef logic [31:0] word_type;
   typedef logic [7:0][31:0] hash_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_ROUND,
      ST_FOLD,
      ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      PASS_DATA,
      PASS_PAD_FIRST,
      PASS_PAD_EXTRA,
      PASS_PAD_ONLY
   } pass_type;

   typedef struct packed {
      logic       load;
      logic       step;
      logic [5:0] round;
   } round_ctl_type;

   localparam hash_type INIT_HASH = {
      32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
      32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
   };

   localparam word_type ROUND_K [ROUNDS] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

endpackage

// File: rtl/sha256mh_if.sv
interface sha256mh_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       has_byte;
   logic       end_of_message;

   modport source (output valid, data_byte, has_byte, end_of_message, input ready);
   modport sink (input valid, data_byte, has_byte, end_of_message, output ready);
endinterface

interface sha256mh_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        last_word;

   modport source (output valid, digest_word, word_index, last_word, input ready);
   modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

// File: rtl/sha256mh_block_buf.sv
module sha256mh_block_buf (
   input  logic        clock,
   input  logic        wr_en,
   input  logic [5:0]  wr_addr,
   input  logic [7:0]  wr_data,
   input  logic [3:0]  rd_addr,
   output logic [31:0] rd_data
);

   // Bytes are stored big-endian within each 32-bit word.
   logic [31:0] mem [sha256mh_pkg::BLOCK_WORDS];
   logic [31:0] rd_data_ff;
   logic [4:0]  lane_lsb;

   assign lane_lsb = {~wr_addr[1:0], 3'b000};

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr[5:2]][lane_lsb +: 8] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/sha256mh_round_unit.sv
module sha256mh_round_unit (
   input  logic                         clock,
   input  sha256mh_pkg::round_ctl_type  ctl,
   input  sha256mh_pkg::hash_type       chain,
   input  sha256mh_pkg::word_type       msg_word,
   output sha256mh_pkg::hash_type       work
);

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   sha256mh_pkg::hash_type work_ff;
   sha256mh_pkg::word_type sched_ff [16];
   sha256mh_pkg::word_type w;
   sha256mh_pkg::word_type s0;
   sha256mh_pkg::word_type s1;
   sha256mh_pkg::word_type t1;
   sha256mh_pkg::word_type t2;

   // The schedule is a shift line: entry 15 is the newest word, entry 0 the oldest.
   always_comb begin
      s0 = rotr(sched_ff[1], 7) ^ rotr(sched_ff[1], 18) ^ (sched_ff[1] >> 3);
      s1 = rotr(sched_ff[14], 17) ^ rotr(sched_ff[14], 19) ^ (sched_ff[14] >> 10);
      if (ctl.round < 6'd16) begin
         w = msg_word;
      end else begin
         w = sched_ff[0] + s0 + sched_ff[9] + s1;
      end
      t1 = work_ff[7]
         + (rotr(work_ff[4], 6) ^ rotr(work_ff[4], 11) ^ rotr(work_ff[4], 25))
         + ((work_ff[4] & work_ff[5]) ^ (~work_ff[4] & work_ff[6]))
         + sha256mh_pkg::ROUND_K[ctl.round] + w;
      t2 = (rotr(work_ff[0], 2) ^ rotr(work_ff[0], 13) ^ rotr(work_ff[0], 22))
         + ((work_ff[0] & work_ff[1]) ^ (work_ff[0] & work_ff[2])
            ^ (work_ff[1] & work_ff[2]));
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         work_ff <= chain;
      end else if (ctl.step) begin
         work_ff[7] <= work_ff[6];
         work_ff[6] <= work_ff[5];
         work_ff[5] <= work_ff[4];
         work_ff[4] <= work_ff[3] + t1;
         work_ff[3] <= work_ff[2];
         work_ff[2] <= work_ff[1];
         work_ff[1] <= work_ff[0];
         work_ff[0] <= t1 + t2;
         for (int i = 0; i < 15; i++) begin
            sched_ff[i] <= sched_ff[i + 1];
         end
         sched_ff[15] <= w;
      end
   end

   assign work = work_ff;

endmodule

// File: rtl/sha256_message_hasher.sv
// A byte that does not complete a block is taken in the cycle it is offered; a byte that
// completes a block then holds ready low through load, the 64 rounds and fold.
// End of message adds one or two blocks of padded compression, then the 8 digest words.
// Ready is low while compressing, so a new byte waits until the block is done.
// Reset (synchronous) restores the initial hash values and clears the bit count.
module sha256_message_hasher (
   input  logic                  clock,
   input  logic                  reset,
   sha256mh_req_if.sink          req_chan,
   sha256mh_rsp_if.source        rsp_chan
);

   function automatic logic [31:0] pad_word(
      input logic [31:0] raw,
      input logic [3:0]  index,
      input logic [6:0]  limit,
      input logic        mark_en,
      input logic        len_en,
      input logic [63:0] count
   );
      logic [31:0] res;
      logic [5:0]  pos;
      logic [7:0]  byte_val;
      for (int b = 0; b < 4; b++) begin
         pos = {index, 2'(b)};
         if ({1'b0, pos} < limit) begin
            byte_val = raw[(3 - b) * 8 +: 8];
         end else if (mark_en && ({1'b0, pos} == limit)) begin
            byte_val = 8'h80;
         end else if (len_en && (pos >= 6'd56)) begin
            byte_val = count[{~pos[2:0], 3'b000} +: 8];
         end else begin
            byte_val = 8'h00;
         end
         res[(3 - b) * 8 +: 8] = byte_val;
      end
      return res;
   endfunction

   sha256mh_pkg::state_type     state_ff, state_in;
   sha256mh_pkg::pass_type      pass_ff, pass_in;
   logic                        eom_ff, eom_in;
   logic [5:0]                  round_ff, round_in;
   logic [63:0]                 count_ff, count_in;
   sha256mh_pkg::hash_type      chain_ff, chain_in;
   logic [2:0]                  out_idx_ff, out_idx_in;

   sha256mh_pkg::round_ctl_type round_ctl;
   sha256mh_pkg::hash_type      work;
   sha256mh_pkg::word_type      msg_word;
   logic [31:0]                 rd_data;
   logic [3:0]                  rd_addr;
   logic                        req_take;
   logic                        wr_en;
   logic [6:0]                  limit;
   logic                        mark_en;
   logic                        len_en;

   assign req_take = req_chan.valid && req_chan.ready;
   assign wr_en    = req_take && req_chan.has_byte;

   always_comb begin
      unique case (pass_ff)
         sha256mh_pkg::PASS_DATA: begin
            limit = 7'd64;
            mark_en = 1'b0;
            len_en = 1'b0;
         end
         sha256mh_pkg::PASS_PAD_FIRST: begin
            limit = {1'b0, count_ff[8:3]};
            mark_en = 1'b1;
            len_en = 1'b0;
         end
         sha256mh_pkg::PASS_PAD_EXTRA: begin
            limit = 7'd0;
            mark_en = 1'b0;
            len_en = 1'b1;
         end
         default: begin
            limit = {1'b0, count_ff[8:3]};
            mark_en = 1'b1;
            len_en = 1'b1;
         end
      endcase
      msg_word = pad_word(rd_data, round_ff[3:0], limit, mark_en, len_en, count_ff);
   end

   always_comb begin
      state_in   = state_ff;
      pass_in    = pass_ff;
      eom_in     = eom_ff;
      round_in   = round_ff;
      count_in   = count_ff;
      chain_in   = chain_ff;
      out_idx_in = out_idx_ff;
      rd_addr    = 4'd0;
      round_ctl  = '{load: 1'b0, step: 1'b0, round: round_ff};
      req_chan.ready = 1'b0;
      rsp_chan.valid = 1'b0;
      unique case (state_ff)
         sha256mh_pkg::ST_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               if (req_chan.has_byte) begin
                  count_in = count_ff + 64'd8;
               end
               eom_in = req_chan.end_of_message;
               if (req_chan.has_byte && (count_ff[8:3] == 6'd63)) begin
                  pass_in  = sha256mh_pkg::PASS_DATA;
                  state_in = sha256mh_pkg::ST_LOAD;
               end else if (req_chan.end_of_message) begin
                  pass_in  = (count_in[8:3] >= 6'd56) ? sha256mh_pkg::PASS_PAD_FIRST
                                                      : sha256mh_pkg::PASS_PAD_ONLY;
                  state_in = sha256mh_pkg::ST_LOAD;
               end
            end
         end
         sha256mh_pkg::ST_LOAD: begin
            round_ctl.load = 1'b1;
            rd_addr  = 4'd0;
            round_in = 6'd0;
            state_in = sha256mh_pkg::ST_ROUND;
         end
         sha256mh_pkg::ST_ROUND: begin
            round_ctl.step = 1'b1;
            rd_addr = round_ff[3:0] + 4'd1;
            if (round_ff == 6'd63) begin
               round_in = 6'd0;
               state_in = sha256mh_pkg::ST_FOLD;
            end else begin
               round_in = round_ff + 6'd1;
            end
         end
         sha256mh_pkg::ST_FOLD: begin
            for (int i = 0; i < 8; i++) begin
               chain_in[i] = chain_ff[i] + work[i];
            end
            priority case (pass_ff)
               sha256mh_pkg::PASS_DATA: begin
                  if (eom_ff) begin
                     pass_in  = (count_ff[8:3] >= 6'd56) ? sha256mh_pkg::PASS_PAD_FIRST
                                                         : sha256mh_pkg::PASS_PAD_ONLY;
                     state_in = sha256mh_pkg::ST_LOAD;
                  end else begin
                     state_in = sha256mh_pkg::ST_IDLE;
                  end
               end
               sha256mh_pkg::PASS_PAD_FIRST: begin
                  pass_in  = sha256mh_pkg::PASS_PAD_EXTRA;
                  state_in = sha256mh_pkg::ST_LOAD;
               end
               default: begin
                  out_idx_in = 3'd0;
                  state_in   = sha256mh_pkg::ST_OUT;
               end
            endcase
         end
         sha256mh_pkg::ST_OUT: begin
            rsp_chan.valid = 1'b1;
            if (rsp_chan.ready) begin
               if (out_idx_ff == 3'd7) begin
                  chain_in = sha256mh_pkg::INIT_HASH;
                  count_in = 64'd0;
                  eom_in   = 1'b0;
                  state_in = sha256mh_pkg::ST_IDLE;
               end else begin
                  out_idx_in = out_idx_ff + 3'd1;
               end
            end
         end
         default: begin
            state_in = sha256mh_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= sha256mh_pkg::ST_IDLE;
         pass_ff    <= sha256mh_pkg::PASS_DATA;
         eom_ff     <= 1'b0;
         round_ff   <= 6'd0;
         count_ff   <= 64'd0;
         chain_ff   <= sha256mh_pkg::INIT_HASH;
         out_idx_ff <= 3'd0;
      end else begin
         state_ff   <= state_in;
         pass_ff    <= pass_in;
         eom_ff     <= eom_in;
         round_ff   <= round_in;
         count_ff   <= count_in;
         chain_ff   <= chain_in;
         out_idx_ff <= out_idx_in;
      end
   end

   assign rsp_chan.digest_word = chain_ff[out_idx_ff];
   assign rsp_chan.word_index  = out_idx_ff;
   assign rsp_chan.last_word   = (out_idx_ff == 3'd7);

   sha256mh_block_buf u_block_buf (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[8:3]),
      .wr_data (req_chan.data_byte),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   sha256mh_round_unit u_round_unit (
      .clock    (clock),
      .ctl      (round_ctl),
      .chain    (chain_ff),
      .msg_word (msg_word),
      .work     (work)
   );

endmodule

// File: rtl/sha256mh_checker.sv
`include "sha256_message_hasher_defines.svh"

module sha256mh_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_word_index,
   input logic        rsp_last_word
);

   logic       mid_take;
   logic       last_take;
   logic       last_ok;
   logic       order_ok;
   logic [2:0] next_index_ff;

   assign mid_take  = rsp_valid && rsp_ready && !rsp_last_word;
   assign last_take = rsp_valid && rsp_ready && rsp_last_word;
   assign last_ok   = (rsp_last_word == (rsp_word_index == 3'd7));
   assign order_ok  = rsp_valid && (rsp_word_index == next_index_ff);

   always_ff @(posedge clock) begin
      next_index_ff <= rsp_word_index + 3'd1;
   end

   `SHAMH_ASSERT_SAME(a_no_overlap, rsp_valid, !req_ready, "ready while digest is pending")
   `SHAMH_ASSERT_SAME(a_last_flag, rsp_valid, last_ok, "last flag mismatch")
   `SHAMH_ASSERT_NEXT(a_word_order, mid_take, order_ok, "digest words out of order")
   `SHAMH_ASSERT_NEXT(a_done, last_take, !rsp_valid && req_ready, "digest did not finish")

endmodule

bind sha256_message_hasher sha256mh_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_word_index (rsp_chan.word_index),
   .rsp_last_word  (rsp_chan.last_word)
);
